// ===== hdl/gpu_stream_dispatch_table_core_defines.svh =====
// Assertion macros used by the dispatch table checker.
// Depends on nothing; expects i_clk and i_rst_n in the scope of use.
`ifndef GPU_STREAM_DISPATCH_TABLE_CORE_DEFINES_SVH
`define GPU_STREAM_DISPATCH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GSDT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gsdt: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GSDT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gsdt: next-cycle check failed");

`endif

// ===== hdl/gsdt_pkg.sv =====
// Shared types and constants of the stream dispatch table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gsdt_pkg;

    localparam int DEF_MAX_STREAMS = 16;
    localparam int DEF_MAX_OPS     = 16;
    localparam int GPU_COUNT       = 16;

    localparam int MODE_W  = 2;
    localparam int IDX_W   = 4;
    localparam int OP_W    = 4;
    localparam int TAG_W   = 16;
    localparam int GPU_W   = 4;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = OP_W + TAG_W;

    localparam logic [OP_W-1:0] FINISH = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_STREAM = 2'd0,
        MODE_ADD_OP     = 2'd1,
        MODE_DISPATCH   = 2'd2,
        MODE_CLEAR      = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 2'd0,
        ST_STREAMS_FULL = 2'd1,
        ST_OPS_FULL     = 2'd2,
        ST_BAD_INDEX    = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    load;        // capture the accepted item
        logic    add_stream;  // open stream at the table end
        logic    append;      // write entry, bump op count, rewind cursor
        logic    rd_head;     // read slot 0 of the selected stream
        logic    scan_step;   // move to next stream
        logic    claim;       // bind selected stream if unbound
        logic    take;        // read entry under cursor, advance, mark found
        logic    rd_next;     // latch tag, read new pending entry
        logic    upd_pend;    // refresh cached pending op and busy count
        logic    clear_all;   // drop all streams
        logic    set_status;
        t_status status;
        logic    out_load;    // move result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_mode mode;
        logic  bad_idx;
        logic  gpu_bad;
        logic  streams_full;
        logic  ops_full;
        logic  scan_end;
        logic  match;
        logic  last_idx;
        logic  has_entry;
        logic  out_free;
    } t_sts;

endpackage

// ===== hdl/gsdt_ctrl.sv =====
// Sequencer of the stream dispatch table: one item at a time.
// Depends on gsdt_pkg; drives gsdt_dpath through t_cmd / t_sts.
`timescale 1ns / 1ps

module gsdt_ctrl
    import gsdt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_FETCH = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_TAG   = 8'b0001_0000,
        S_UPD   = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_sts.mode)
                    MODE_ADD_STREAM: begin
                        if (i_sts.streams_full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_STREAMS_FULL;
                        end else begin
                            o_cmd.add_stream = 1'b1;
                        end
                    end
                    MODE_ADD_OP: begin
                        if (i_sts.bad_idx) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_BAD_INDEX;
                        end else if (i_sts.ops_full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_OPS_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                            n_state      = S_FETCH;
                        end
                    end
                    MODE_DISPATCH: begin
                        if (!i_sts.gpu_bad) begin
                            n_state = S_SCAN;
                        end
                    end
                    MODE_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_FETCH: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_UPD;
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = S_DONE;
                end else if (i_sts.match) begin
                    o_cmd.claim = 1'b1;
                    if (i_sts.has_entry) begin
                        o_cmd.take = 1'b1;
                        n_state    = S_TAG;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_sts.last_idx) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_TAG: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_pend = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== hdl/gsdt_dpath.sv =====
// Datapath of the stream dispatch table: per-stream registers, entry memory,
// output register. Depends on gsdt_pkg; commanded by gsdt_ctrl.
`timescale 1ns / 1ps

module gsdt_dpath
    import gsdt_pkg::*;
#(
    parameter int MAX_STREAMS = DEF_MAX_STREAMS,
    parameter int MAX_OPS     = DEF_MAX_OPS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [IDX_W-1:0] i_stream_index,
    input  logic [OP_W-1:0]  i_op_code,
    input  logic [TAG_W-1:0] i_call_tag,
    input  logic [GPU_W-1:0] i_gpu_id,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_found,
    output logic [IDX_W-1:0] o_served_stream,
    output logic [TAG_W-1:0] o_served_tag,
    output logic             o_all_finished,
    output logic [STAT_W-1:0] o_status
);

    localparam int SW    = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int OW    = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int CW    = $clog2(MAX_OPS + 1);
    localparam int TW    = $clog2(MAX_STREAMS + 1);
    localparam int DEPTH = MAX_STREAMS * MAX_OPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // item registers
    t_mode            r_mode;
    logic [OP_W-1:0]  r_op;
    logic [TAG_W-1:0] r_tag;
    logic [GPU_W-1:0] r_gpu;
    logic             r_bad_idx;
    logic             r_gpu_bad;
    logic [SW-1:0]    r_idx;
    logic             r_rd_ok;
    logic             r_found;
    logic [TAG_W-1:0] r_tag_w;
    t_status          r_status_w;

    // table state
    logic [TW-1:0]    r_total;
    logic [TW-1:0]    r_busy;     // streams whose pending op is not FINISH
    logic [CW-1:0]    r_op_total [MAX_STREAMS];
    logic [CW-1:0]    r_cursor   [MAX_STREAMS];
    logic             r_bound    [MAX_STREAMS];
    logic [GPU_W-1:0] r_bgpu     [MAX_STREAMS];
    logic [OP_W-1:0]  r_pend     [MAX_STREAMS];

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    // output register
    logic             r_out_valid;
    logic             r_o_found;
    logic [IDX_W-1:0] r_o_stream;
    logic [TAG_W-1:0] r_o_tag;
    logic             r_o_fin;
    t_status          r_o_status;

    logic [CW-1:0]    cur_total;
    logic [CW-1:0]    cur_cursor;
    logic             cur_bound;
    logic [GPU_W-1:0] cur_bgpu;
    logic [OP_W-1:0]  cur_pend;
    logic             has_entry;
    logic [AW-1:0]    base;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [OW-1:0]    rd_slot;
    logic             rd_en;
    logic [OP_W-1:0]  new_pend;
    logic             out_free;

    assign cur_total  = r_op_total[r_idx];
    assign cur_cursor = r_cursor[r_idx];
    assign cur_bound  = r_bound[r_idx];
    assign cur_bgpu   = r_bgpu[r_idx];
    assign cur_pend   = r_pend[r_idx];
    assign has_entry  = (cur_cursor < cur_total);

    assign base    = AW'(r_idx) * AW'(MAX_OPS);
    assign rd_slot = has_entry ? OW'(cur_cursor) : '0;
    assign wr_addr = base + AW'(OW'(cur_total));
    assign rd_addr = base + AW'(rd_slot);
    assign rd_en   = i_cmd.rd_head | i_cmd.take | i_cmd.rd_next;

    assign new_pend = r_rd_ok ? r_rdata[ENTRY_W-1:TAG_W] : FINISH;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts.mode         = r_mode;
        o_sts.bad_idx      = r_bad_idx;
        o_sts.gpu_bad      = r_gpu_bad;
        o_sts.streams_full = (32'(r_total) >= MAX_STREAMS);
        o_sts.ops_full     = (32'(cur_total) >= MAX_OPS);
        o_sts.scan_end     = (32'(r_idx) >= 32'(r_total));
        o_sts.match        = (cur_pend == r_op) && (!cur_bound || (cur_bgpu == r_gpu));
        o_sts.last_idx     = (32'(r_idx) == MAX_STREAMS - 1);
        o_sts.has_entry    = has_entry;
        o_sts.out_free     = out_free;
    end

    // entry memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[wr_addr] <= {r_op, r_tag};
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // item registers (no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= t_mode'(i_mode);
            r_op       <= i_op_code;
            r_tag      <= i_call_tag;
            r_gpu      <= i_gpu_id;
            r_bad_idx  <= (32'(i_stream_index) >= MAX_STREAMS) ||
                          (32'(i_stream_index) >= 32'(r_total));
            r_gpu_bad  <= (32'(i_gpu_id) >= GPU_COUNT);
            r_found    <= 1'b0;
            r_tag_w    <= '0;
            r_status_w <= ST_OK;
            case (t_mode'(i_mode))
                MODE_ADD_OP:     r_idx <= SW'(i_stream_index);
                MODE_ADD_STREAM: r_idx <= SW'(r_total);
                default:         r_idx <= '0;
            endcase
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + SW'(1);
        end
        if (i_cmd.set_status) begin
            r_status_w <= i_cmd.status;
        end
        if (i_cmd.take) begin
            r_found <= 1'b1;
        end
        if (i_cmd.rd_head) begin
            r_rd_ok <= 1'b1;
        end
        if (i_cmd.rd_next) begin
            r_tag_w <= r_rdata[TAG_W-1:0];
            r_rd_ok <= has_entry;
        end
        if (i_cmd.out_load) begin
            r_o_found  <= r_found;
            r_o_stream <= r_found ? IDX_W'(r_idx) : '0;
            r_o_tag    <= r_tag_w;
            r_o_fin    <= (r_busy == '0);
            r_o_status <= r_status_w;
        end
    end

    // table state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < MAX_STREAMS; s++) begin
                r_op_total[s] <= '0;
                r_cursor[s]   <= '0;
                r_bound[s]    <= 1'b0;
                r_bgpu[s]     <= '0;
                r_pend[s]     <= FINISH;
            end
        end else begin
            if (i_cmd.clear_all) begin
                r_total <= '0;
                r_busy  <= '0;
                for (int s = 0; s < MAX_STREAMS; s++) begin
                    r_op_total[s] <= '0;
                    r_cursor[s]   <= '0;
                    r_bound[s]    <= 1'b0;
                    r_bgpu[s]     <= '0;
                    r_pend[s]     <= FINISH;
                end
            end
            if (i_cmd.add_stream) begin
                r_op_total[r_idx] <= '0;
                r_cursor[r_idx]   <= '0;
                r_bound[r_idx]    <= 1'b0;
                r_bgpu[r_idx]     <= '0;
                r_pend[r_idx]     <= FINISH;
                r_total           <= r_total + TW'(1);
            end
            if (i_cmd.append) begin
                r_op_total[r_idx] <= cur_total + CW'(1);
                r_cursor[r_idx]   <= '0;
            end
            if (i_cmd.claim && !cur_bound) begin
                r_bound[r_idx] <= 1'b1;
                r_bgpu[r_idx]  <= r_gpu;
            end
            if (i_cmd.take) begin
                r_cursor[r_idx] <= cur_cursor + CW'(1);
            end
            if (i_cmd.upd_pend) begin
                r_pend[r_idx] <= new_pend;
                if ((cur_pend == FINISH) && (new_pend != FINISH)) begin
                    r_busy <= r_busy + TW'(1);
                end else if ((cur_pend != FINISH) && (new_pend == FINISH)) begin
                    r_busy <= r_busy - TW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_o_found;
    assign o_served_stream = r_o_stream;
    assign o_served_tag    = r_o_tag;
    assign o_all_finished  = r_o_fin;
    assign o_status        = r_o_status;

endmodule

// ===== hdl/gpu_stream_dispatch_table_core.sv =====
// Path from accept to result in the output register: add stream, clear, refused add op and
// out-of-range gpu pass EXEC, DONE; add op EXEC, FETCH, UPD, DONE; dispatch EXEC, SCAN, DONE,
// or EXEC, SCAN, TAG, UPD, DONE when a call is handed out. SCAN visits the streams in turn,
// stopping on a match, at the last slot or past the table end. One item is in flight at a time.
// A waiting result does not block the next accept; it holds only the final hand-off.
// Reset (i_rst_n low, synchronous): no streams, counters/cursors/bindings zero, output empty.
`timescale 1ns / 1ps

module gpu_stream_dispatch_table_core
    import gsdt_pkg::*;
#(
    parameter int MAX_STREAMS = DEF_MAX_STREAMS,  // 1..16
    parameter int MAX_OPS     = DEF_MAX_OPS       // 1..256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input item
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [IDX_W-1:0]  i_stream_index,
    input  logic [OP_W-1:0]   i_op_code,
    input  logic [TAG_W-1:0]  i_call_tag,
    input  logic [GPU_W-1:0]  i_gpu_id,
    // result item
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_found,
    output logic [IDX_W-1:0]  o_served_stream,
    output logic [TAG_W-1:0]  o_served_tag,
    output logic              o_all_finished,
    output logic [STAT_W-1:0] o_status
);

    // Controller walks each item through EXEC, optional memory reads and
    // the scan; the datapath holds per-stream state in flops (one row picked
    // by a single index register) and the entries in a one-port-each RAM.
    // The entry RAM is never cleared: only written entries are ever read.
    //
    // Each stream caches its pending op code, so the scan compares one
    // stream per cycle without touching the RAM. The cache is refreshed
    // after any cursor move by reading the new pending entry.
    //
    // all_finished comes from a count of streams whose pending op is not
    // FINISH, kept up to date on every cache refresh.

    t_cmd cmd;
    t_sts sts;

    gsdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gsdt_dpath #(
        .MAX_STREAMS (MAX_STREAMS),
        .MAX_OPS     (MAX_OPS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_stream_index  (i_stream_index),
        .i_op_code       (i_op_code),
        .i_call_tag      (i_call_tag),
        .i_gpu_id        (i_gpu_id),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_served_stream (o_served_stream),
        .o_served_tag    (o_served_tag),
        .o_all_finished  (o_all_finished),
        .o_status        (o_status)
    );

endmodule

// ===== hdl/gsdt_checker.sv =====
// Port-level checks of the stream dispatch table, bound to the top level.
// Depends on gsdt_pkg and gpu_stream_dispatch_table_core_defines.svh.
`timescale 1ns / 1ps
`include "gpu_stream_dispatch_table_core_defines.svh"

module gsdt_checker
    import gsdt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [MODE_W-1:0] i_mode,
    input logic [IDX_W-1:0]  i_stream_index,
    input logic [OP_W-1:0]   i_op_code,
    input logic [TAG_W-1:0]  i_call_tag,
    input logic [GPU_W-1:0]  i_gpu_id,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_found,
    input logic [IDX_W-1:0]  o_served_stream,
    input logic [TAG_W-1:0]  o_served_tag,
    input logic              o_all_finished,
    input logic [STAT_W-1:0] o_status
);

    // result held under stall
    `GSDT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `GSDT_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_served_tag) && $stable(o_served_stream) && $stable(o_found) && $stable(o_status) && $stable(o_all_finished))

    // the block is busy in the cycle after it accepts an item
    `GSDT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // a served call always carries ok status
    `GSDT_ASSERT_NOW(a_found_ok, o_out_valid && o_found, o_status == ST_OK)

    // nothing handed out means zero stream and tag
    `GSDT_ASSERT_NOW(a_miss_zero, o_out_valid && !o_found, (o_served_tag == '0) && (o_served_stream == '0))

endmodule

bind gpu_stream_dispatch_table_core gsdt_checker u_gsdt_checker (.*);
